// ===== design/bcc_pkg.sv =====
// Shared constants, codes and types for the button click classifier.
`default_nettype none
package bcc_pkg;

	// Default parameter values
	localparam int BUTTONS_DEF     = 2;
	localparam int COUNT_BITS_DEF  = 12;
	localparam int QUEUE_DEPTH_DEF = 4;

	// Configuration port
	localparam int CFG_BITS       = 12;
	localparam int CFG_INDEX_BITS = 2;

	localparam logic [CFG_INDEX_BITS-1:0] REG_DOUBLE_CLICK = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_LONG_PRESS   = 2'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_VLONG_PRESS  = 2'd2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_REPORT_EDGES = 2'd3;

	localparam logic [CFG_BITS-1:0] DOUBLE_CLICK_RST = 12'd10;
	localparam logic [CFG_BITS-1:0] LONG_PRESS_RST   = 12'd50;
	localparam logic [CFG_BITS-1:0] VLONG_PRESS_RST  = 12'd150;

	// Events per tick are capped
	localparam int MAX_RESULTS = 4;
	localparam int SENT_BITS   = $clog2(MAX_RESULTS);

	// Event codes
	localparam int CODE_BITS = 3;
	localparam logic [CODE_BITS-1:0] EV_PRESS   = 3'd0;
	localparam logic [CODE_BITS-1:0] EV_RELEASE = 3'd1;
	localparam logic [CODE_BITS-1:0] EV_CLICK   = 3'd2;
	localparam logic [CODE_BITS-1:0] EV_DOUBLE  = 3'd3;
	localparam logic [CODE_BITS-1:0] EV_LONG    = 3'd4;
	localparam logic [CODE_BITS-1:0] EV_VLONG   = 3'd5;

	// Tick-record queue status
	typedef struct packed {
		logic empty;
		logic full;
	} bcc_qstat_t;

endpackage
`default_nettype wire

// ===== design/bcc_front.sv =====
// Front end: debounce, per-button phase machines, builds one event record per accepted tick that has events.
`default_nettype none
module bcc_front #(
	parameter int BUTTONS    = bcc_pkg::BUTTONS_DEF,
	parameter int COUNT_BITS = bcc_pkg::COUNT_BITS_DEF
) (
	input  wire logic                                    clk,
	input  wire logic                                    arst_n,
	input  wire logic                                    accept,
	input  wire logic [BUTTONS-1:0]                      raw_levels,
	input  wire logic [bcc_pkg::CFG_BITS-1:0]            double_click_ticks,
	input  wire logic [bcc_pkg::CFG_BITS-1:0]            long_press_ticks,
	input  wire logic [bcc_pkg::CFG_BITS-1:0]            very_long_press_ticks,
	input  wire logic                                    report_edges,
	output logic                                         rec_push,
	output logic [2*BUTTONS-1:0]                         rec_vld,
	output logic [2*BUTTONS*bcc_pkg::CODE_BITS-1:0]      rec_codes
);
	import bcc_pkg::*;

	localparam int SLOTS    = 2 * BUTTONS;
	localparam int CMP_BITS = (COUNT_BITS > CFG_BITS) ? COUNT_BITS : CFG_BITS;

	// Phase codes
	localparam logic [1:0] PH_IDLE   = 2'd0;
	localparam logic [1:0] PH_CLICK  = 2'd1;
	localparam logic [1:0] PH_DOUBLE = 2'd2;
	localparam logic [1:0] PH_LONG   = 2'd3;

	logic [BUTTONS-1:0]    prev_q;
	logic [BUTTONS-1:0]    deb_q;
	logic [1:0]            phase_q [BUTTONS];
	logic [COUNT_BITS-1:0] hold_q  [BUTTONS];

	logic [BUTTONS-1:0]    level;
	logic [BUTTONS-1:0]    keys;
	logic [BUTTONS-1:0]    trig;
	logic [1:0]            phase_d [BUTTONS];
	logic [COUNT_BITS-1:0] hold_d  [BUTTONS];
	logic [CODE_BITS-1:0]  code_d  [SLOTS];

	// Debounce: take the sample only when it matches the previous one
	assign level = ~raw_levels;
	assign keys  = (level & prev_q) | ((level ^ prev_q) & deb_q);
	assign trig  = keys ^ deb_q;

	// Per-button classification, buttons are independent
	always_comb begin
		logic [COUNT_BITS-1:0] inc;
		logic [CMP_BITS-1:0]   hold_x;
		logic [CMP_BITS-1:0]   inc_x;
		inc    = '0;
		hold_x = '0;
		inc_x  = '0;
		rec_vld = '0;
		for (int n = 0; n < BUTTONS; n++) begin
			phase_d[n]    = phase_q[n];
			hold_d[n]     = hold_q[n];
			code_d[2*n]   = keys[n] ? EV_PRESS : EV_RELEASE;
			code_d[2*n+1] = EV_CLICK;
			inc    = hold_q[n] + 1'b1;
			hold_x = CMP_BITS'(hold_q[n]);
			inc_x  = CMP_BITS'(inc);
			if (keys[n]) begin
				if (trig[n]) begin
					rec_vld[2*n] = report_edges;
					if (phase_q[n] == PH_CLICK) begin
						if (hold_x < CMP_BITS'(double_click_ticks))
							phase_d[n] = PH_DOUBLE;
					end else begin
						phase_d[n] = PH_CLICK;
					end
					hold_d[n] = '0;
				end else if (phase_q[n] != PH_IDLE) begin
					hold_d[n] = inc;
					if (inc_x == CMP_BITS'(long_press_ticks)) begin
						phase_d[n]      = PH_LONG;
						rec_vld[2*n+1]  = 1'b1;
						code_d[2*n+1]   = EV_LONG;
					end else if (inc_x >= CMP_BITS'(very_long_press_ticks)) begin
						phase_d[n]      = PH_IDLE;
						rec_vld[2*n+1]  = 1'b1;
						code_d[2*n+1]   = EV_VLONG;
					end
				end
			end else begin
				if (trig[n]) begin
					rec_vld[2*n] = report_edges;
					if (phase_q[n] == PH_DOUBLE) begin
						phase_d[n]     = PH_IDLE;
						rec_vld[2*n+1] = 1'b1;
						code_d[2*n+1]  = EV_DOUBLE;
					end
					hold_d[n] = '0;
				end else if (phase_q[n] == PH_CLICK) begin
					hold_d[n] = inc;
					if (inc_x >= CMP_BITS'(double_click_ticks)) begin
						phase_d[n]     = PH_IDLE;
						rec_vld[2*n+1] = 1'b1;
						code_d[2*n+1]  = EV_CLICK;
					end
				end
			end
		end
	end

	// Pack codes into the record
	always_comb begin
		for (int s = 0; s < SLOTS; s++)
			rec_codes[CODE_BITS*s +: CODE_BITS] = code_d[s];
	end

	// Ticks with no event leave no record
	assign rec_push = accept && (|rec_vld);

	// State update on each accepted tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
			deb_q  <= '0;
			for (int n = 0; n < BUTTONS; n++) begin
				phase_q[n] <= PH_IDLE;
				hold_q[n]  <= '0;
			end
		end else if (accept) begin
			prev_q <= level;
			deb_q  <= keys;
			for (int n = 0; n < BUTTONS; n++) begin
				phase_q[n] <= phase_d[n];
				hold_q[n]  <= hold_d[n];
			end
		end
	end

endmodule
`default_nettype wire

// ===== design/bcc_queue.sv =====
// Short first-word-fall-through queue of tick records between front and back.
`default_nettype none
module bcc_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = bcc_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             pop,
	output logic [WIDTH-1:0]      rdata,
	output bcc_pkg::bcc_qstat_t   stat
);
	import bcc_pkg::*;

	localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_BITS = $clog2(DEPTH + 1);

	logic [WIDTH-1:0]    mem_q [DEPTH];
	logic [PTR_BITS-1:0] wptr_q;
	logic [PTR_BITS-1:0] rptr_q;
	logic [CNT_BITS-1:0] count_q;

	assign stat.empty = (count_q == '0);
	assign stat.full  = (count_q == CNT_BITS'(DEPTH));
	assign rdata      = mem_q[rptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wptr_q] <= wdata;
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push)
				wptr_q <= (wptr_q == PTR_BITS'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			if (pop)
				rptr_q <= (rptr_q == PTR_BITS'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule
`default_nettype wire

// ===== design/bcc_back.sv =====
// Back end: walks a tick record and issues its events one per cycle into the output register while free or popped.
`default_nettype none
module bcc_back #(
	parameter int BUTTONS = bcc_pkg::BUTTONS_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                head_valid,
	input  wire logic [2*BUTTONS-1:0]                head_vld,
	input  wire logic [2*BUTTONS*bcc_pkg::CODE_BITS-1:0] head_codes,
	output logic                                     head_pop,
	input  wire logic                                pop,
	output logic                                     empty,
	output logic                                     button_index,
	output logic [bcc_pkg::CODE_BITS-1:0]            event_code,
	output logic                                     last_of_tick
);
	import bcc_pkg::*;

	localparam int SLOTS     = 2 * BUTTONS;
	localparam int SLOT_BITS = $clog2(SLOTS);

	logic                 out_vld_q;
	logic [SLOTS-1:0]     taken_q;
	logic [SENT_BITS-1:0] sent_q;

	logic [SLOTS-1:0]     rem;
	logic [SLOTS-1:0]     low;
	logic [SLOTS-1:0]     rem_after;
	logic [SLOT_BITS-1:0] idx;
	logic                 load;
	logic                 is_last;

	// Next event: lowest slot not yet issued
	assign rem       = head_vld & ~taken_q;
	assign low       = rem & (~rem + 1'b1);
	assign rem_after = rem & ~low;

	always_comb begin
		idx = '0;
		for (int s = 0; s < SLOTS; s++)
			if (low[s])
				idx = SLOT_BITS'(s);
	end

	assign is_last  = (rem_after == '0) || (sent_q == SENT_BITS'(MAX_RESULTS - 1));
	assign load     = head_valid && (!out_vld_q || pop);
	assign head_pop = load && is_last;
	assign empty    = !out_vld_q;

	// Walk state within the head record
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			taken_q   <= '0;
			sent_q    <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (load) begin
				out_vld_q <= 1'b1;
				if (is_last) begin
					taken_q <= '0;
					sent_q  <= '0;
				end else begin
					taken_q <= taken_q | low;
					sent_q  <= sent_q + 1'b1;
				end
			end else if (pop) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (load) begin
			button_index <= 1'(idx >> 1);
			event_code   <= head_codes[CODE_BITS*idx +: CODE_BITS];
			last_of_tick <= is_last;
		end
	end

endmodule
`default_nettype wire

// ===== design/button_click_classifier.sv =====
// Top level of the button click classifier: config registers, front, record queue, back.
//
//  channel  | handshake       | payload
//  ---------+-----------------+---------------------------------------------
//  ticks in | push / full     | raw_levels
//  events   | empty / pop     | button_index, event_code, last_of_tick
//  config   | cfg_we          | cfg_index, cfg_data
//
// A tick is classified in the cycle it is accepted; a new tick can enter every
// cycle while the record queue has room. The back end issues one event per
// cycle while its output register is free or popped; ticks with no event never
// reach it; a record carries 1 to 4 events. full rises when the record queue
// holds QUEUE_DEPTH ticks. Reset clears debounce state, phases, counters, queue
// and the output valid flag, and loads the configuration defaults.
`default_nettype none
module button_click_classifier #(
	parameter int BUTTONS     = bcc_pkg::BUTTONS_DEF,
	parameter int COUNT_BITS  = bcc_pkg::COUNT_BITS_DEF,
	parameter int QUEUE_DEPTH = bcc_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_we,
	input  wire logic [bcc_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  wire logic [bcc_pkg::CFG_BITS-1:0]       cfg_data,
	input  wire logic                               push,
	output logic                                    full,
	input  wire logic [BUTTONS-1:0]                 raw_levels,
	output logic                                    empty,
	input  wire logic                               pop,
	output logic                                    button_index,
	output logic [bcc_pkg::CODE_BITS-1:0]           event_code,
	output logic                                    last_of_tick
);
	import bcc_pkg::*;

	localparam int SLOTS    = 2 * BUTTONS;
	localparam int REC_BITS = SLOTS + SLOTS * CODE_BITS;

	logic [CFG_BITS-1:0] double_click_q;
	logic [CFG_BITS-1:0] long_press_q;
	logic [CFG_BITS-1:0] vlong_press_q;
	logic                report_edges_q;

	logic                       accept;
	logic                       q_push;
	logic                       q_pop;
	logic [SLOTS-1:0]           rec_vld;
	logic [SLOTS*CODE_BITS-1:0] rec_codes;
	logic [REC_BITS-1:0]        head;
	bcc_qstat_t                 qstat;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			double_click_q <= DOUBLE_CLICK_RST;
			long_press_q   <= LONG_PRESS_RST;
			vlong_press_q  <= VLONG_PRESS_RST;
			report_edges_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_DOUBLE_CLICK: double_click_q <= cfg_data;
				REG_LONG_PRESS:   long_press_q   <= cfg_data;
				REG_VLONG_PRESS:  vlong_press_q  <= cfg_data;
				REG_REPORT_EDGES: report_edges_q <= cfg_data[0];
			endcase
		end
	end

	assign full   = qstat.full;
	assign accept = push && !qstat.full;

	bcc_front #(
		.BUTTONS    (BUTTONS),
		.COUNT_BITS (COUNT_BITS)
	) u_front (
		.clk                   (clk),
		.arst_n                (arst_n),
		.accept                (accept),
		.raw_levels            (raw_levels),
		.double_click_ticks    (double_click_q),
		.long_press_ticks      (long_press_q),
		.very_long_press_ticks (vlong_press_q),
		.report_edges          (report_edges_q),
		.rec_push              (q_push),
		.rec_vld               (rec_vld),
		.rec_codes             (rec_codes)
	);

	bcc_queue #(
		.WIDTH (REC_BITS),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  ({rec_codes, rec_vld}),
		.pop    (q_pop),
		.rdata  (head),
		.stat   (qstat)
	);

	bcc_back #(
		.BUTTONS (BUTTONS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (!qstat.empty),
		.head_vld     (head[SLOTS-1:0]),
		.head_codes   (head[REC_BITS-1:SLOTS]),
		.head_pop     (q_pop),
		.pop          (pop),
		.empty        (empty),
		.button_index (button_index),
		.event_code   (event_code),
		.last_of_tick (last_of_tick)
	);

`ifndef SYNTHESIS
	// Record queue never claims to be empty and full at once
	a_qstat: assert property (@(posedge clk) disable iff (!arst_n)
		!(qstat.empty && qstat.full))
		else $error("record queue empty and full together");

	// Front never pushes a record into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_push && qstat.full))
		else $error("record pushed into full queue");

	// Back never retires a record that is not there
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_pop && qstat.empty))
		else $error("record popped from empty queue");

	// A record retired by the back end leaves a result in the output register
	a_pop_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> !empty)
		else $error("record retired without a result");
`endif

endmodule
`default_nettype wire
